FILE: src/saat_pkg.sv
// ---------------------------------------------------------------------------
// saat_pkg: shared types and constants of the sorted address annotation table
// Request and result codes, the queued request and result records, the engine states and a text helper.
// ---------------------------------------------------------------------------
`default_nettype none

package saat_pkg;

    localparam logic [1:0] REQ_SET_LABEL   = 2'd0;
    localparam logic [1:0] REQ_SET_COMMENT = 2'd1;
    localparam logic [1:0] REQ_GET_LABEL   = 2'd2;
    localparam logic [1:0] REQ_GET_COMMENT = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;

    // Word counter width: holds any word index of the longest text (values up to 63).
    localparam int K_W     = 6;
    localparam int MAX_OUT = 16;

    localparam logic [63:0] TOP_BYTE_CLEAR = 64'h00FF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic        is_get;
        logic        is_label;
        logic [63:0] addr;
        logic [3:0]  widx;
        logic [63:0] word;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] text;
        logic        last;
    } t_res;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH,
        ST_CMP,
        ST_DECIDE,
        ST_SHRD,
        ST_SHWR,
        ST_INS,
        ST_CLR,
        ST_WR,
        ST_RESP,
        ST_GRD,
        ST_GOUT
    } t_state;

    function automatic logic f_has_zero_byte(input logic [63:0] w);
        logic z;
        z = 1'b0;
        for (int b = 0; b < 8; b++) begin
            if (w[8*b +: 8] == 8'd0) z = 1'b1;
        end
        return z;
    endfunction

endpackage

`default_nettype wire

FILE: src/saat_front.sv
// ---------------------------------------------------------------------------
// saat_front: request intake
// Decodes the request kind and holds accepted beats in a two-entry queue.
// ---------------------------------------------------------------------------
`default_nettype none

module saat_front import saat_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [63:0] i_address,
    input  wire logic [3:0]  i_word_index,
    input  wire logic [63:0] i_text_word,
    output logic             o_q_valid,
    input  wire logic        i_q_ready,
    output t_req             o_q_req
);

    t_req       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_req       w_req;
    logic       w_push, w_pop;

    always_comb begin
        w_req.is_get   = (i_req_type == REQ_GET_LABEL) || (i_req_type == REQ_GET_COMMENT);
        w_req.is_label = (i_req_type == REQ_SET_LABEL) || (i_req_type == REQ_GET_LABEL);
        w_req.addr     = i_address;
        w_req.widx     = i_word_index;
        w_req.word     = i_text_word;
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_req   = r_mem[r_rp];
    assign w_push    = i_valid && o_ready;
    assign w_pop     = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= w_req;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

`default_nettype wire

FILE: src/saat_back.sv
// ---------------------------------------------------------------------------
// saat_back: table engine
// Binary search over the sorted key memory, insertion by shifting, and text
// writes and reads through the slot-indexed label and comment memories.
// ---------------------------------------------------------------------------
`default_nettype none

module saat_back import saat_pkg::*; #(
    parameter int CAPACITY      = 256,
    parameter int LABEL_WORDS   = 8,
    parameter int COMMENT_WORDS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    output logic      o_q_ready,
    input  wire t_req i_q_req,
    output logic      o_res_valid,
    input  wire logic i_res_ready,
    output t_res      o_res
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int LW_AW = (LABEL_WORDS > 1) ? $clog2(LABEL_WORDS) : 1;
    localparam int CW_AW = (COMMENT_WORDS > 1) ? $clog2(COMMENT_WORDS) : 1;
    localparam int MAXW  = (LABEL_WORDS > COMMENT_WORDS) ? LABEL_WORDS : COMMENT_WORDS;
    localparam int KEY_W = 64 + IDX_W;

    // Key memory: sorted keys, each with the slot that holds its texts.
    logic [KEY_W-1:0]  kmem [CAPACITY];
    logic [63:0]       lmem [CAPACITY << LW_AW];
    logic [63:0]       cmem [CAPACITY << CW_AW];

    t_state            r_state, n_state;
    t_req              r_req, n_req;
    logic [CNT_W-1:0]  r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic [CNT_W-1:0]  r_j, n_j, r_pos, n_pos, r_count, n_count;
    logic [IDX_W-1:0]  r_slot, n_slot;
    logic              r_found, n_found, r_ins, n_ins;
    logic [1:0]        r_status, n_status;
    logic [K_W-1:0]    r_k, n_k;

    logic [KEY_W-1:0]  r_kdata;
    logic [63:0]       r_ldata, r_cdata;

    logic [IDX_W-1:0]  k_ra, k_wa;
    logic              k_we;
    logic [KEY_W-1:0]  k_wd;
    logic [IDX_W+LW_AW-1:0] l_ra, l_wa;
    logic [IDX_W+CW_AW-1:0] c_ra, c_wa;
    logic              l_we, c_we;
    logic [63:0]       l_wd, c_wd;

    logic [K_W-1:0]    w_words, w_widx, w_nlast;
    logic              w_wr_ok, w_clr_txt, w_cmp_lt, w_cmp_gt;
    logic [63:0]       w_key, w_gword, w_wword;
    logic              w_empty, w_glast;

    always_comb begin
        w_words   = r_req.is_label ? K_W'(LABEL_WORDS) : K_W'(COMMENT_WORDS);
        w_widx    = K_W'(r_req.widx);
        w_wr_ok   = w_widx < w_words;
        w_clr_txt = w_wr_ok && (r_req.widx == 4'd0);
        w_nlast   = ((w_words > K_W'(MAX_OUT)) ? K_W'(MAX_OUT) : w_words) - K_W'(1);
        w_key     = r_kdata[KEY_W-1:IDX_W];
        w_cmp_lt  = w_key < r_req.addr;
        w_cmp_gt  = w_key > r_req.addr;
        w_gword   = r_req.is_label ? r_ldata : r_cdata;
        w_empty   = (r_k == K_W'(0)) && (w_gword[7:0] == 8'd0);
        w_glast   = w_empty || f_has_zero_byte(w_gword) || (r_k == w_nlast);
        w_wword   = (w_widx == w_words - K_W'(1)) ? (r_req.word & TOP_BYTE_CLEAR)
                                                  : r_req.word;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_q_valid) n_state = ST_SRCH;
            ST_SRCH:   n_state = (r_lo < r_hi) ? ST_CMP : ST_DECIDE;
            ST_CMP:    n_state = (!w_cmp_lt && !w_cmp_gt) ? ST_DECIDE : ST_SRCH;
            ST_DECIDE: begin
                if (r_req.is_get) begin
                    n_state = r_found ? ST_GRD : ST_RESP;
                end else if (r_found) begin
                    n_state = w_clr_txt ? ST_CLR : (w_wr_ok ? ST_WR : ST_RESP);
                end else begin
                    n_state = (r_count == CNT_W'(CAPACITY)) ? ST_RESP : ST_SHRD;
                end
            end
            ST_SHRD:   n_state = (r_j > r_pos) ? ST_SHWR : ST_INS;
            ST_SHWR:   n_state = ST_SHRD;
            ST_INS:    n_state = ST_CLR;
            ST_CLR:    if (r_k == K_W'(MAXW - 1)) n_state = w_wr_ok ? ST_WR : ST_RESP;
            ST_WR:     n_state = ST_RESP;
            ST_RESP:   if (i_res_ready) n_state = ST_IDLE;
            ST_GRD:    n_state = ST_GOUT;
            ST_GOUT:   if (i_res_ready) n_state = w_glast ? ST_IDLE : ST_GRD;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs, memory controls and datapath updates
    always_comb begin
        n_req    = r_req;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_j      = r_j;
        n_pos    = r_pos;
        n_count  = r_count;
        n_slot   = r_slot;
        n_found  = r_found;
        n_ins    = r_ins;
        n_status = r_status;
        n_k      = r_k;
        o_q_ready   = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '{status: r_status, text: 64'd0, last: 1'b1};
        k_ra = r_mid[IDX_W-1:0];
        k_we = 1'b0;
        k_wa = r_j[IDX_W-1:0];
        k_wd = r_kdata;
        l_ra = {r_slot, r_k[LW_AW-1:0]};
        c_ra = {r_slot, r_k[CW_AW-1:0]};
        l_we = 1'b0;
        c_we = 1'b0;
        l_wa = {r_slot, r_k[LW_AW-1:0]};
        c_wa = {r_slot, r_k[CW_AW-1:0]};
        l_wd = 64'd0;
        c_wd = 64'd0;
        case (r_state)
            ST_IDLE: begin
                o_q_ready = 1'b1;
                n_req   = i_q_req;
                n_lo    = '0;
                n_hi    = r_count;
                n_found = 1'b0;
                n_ins   = 1'b0;
            end
            ST_SRCH: begin
                n_mid = r_lo + ((r_hi - r_lo) >> 1);
                k_ra  = n_mid[IDX_W-1:0];
                n_pos = r_lo;
            end
            ST_CMP: begin
                if (w_cmp_lt) begin
                    n_lo = r_mid + CNT_W'(1);
                end else if (w_cmp_gt) begin
                    n_hi = r_mid;
                end else begin
                    n_found = 1'b1;
                    n_pos   = r_mid;
                    n_slot  = r_kdata[IDX_W-1:0];
                end
            end
            ST_DECIDE: begin
                n_k      = '0;
                n_j      = r_count;
                n_status = STAT_OK;
                if (r_req.is_get) begin
                    if (!r_found) n_status = STAT_NOTFOUND;
                end else if (!r_found && (r_count == CNT_W'(CAPACITY))) begin
                    n_status = STAT_FULL;
                end
            end
            ST_SHRD: begin
                k_ra = IDX_W'(r_j - CNT_W'(1));
            end
            ST_SHWR: begin
                k_we = 1'b1;
                n_j  = r_j - CNT_W'(1);
            end
            ST_INS: begin
                k_we    = 1'b1;
                k_wa    = r_pos[IDX_W-1:0];
                k_wd    = {r_req.addr, r_count[IDX_W-1:0]};
                n_slot  = r_count[IDX_W-1:0];
                n_count = r_count + CNT_W'(1);
                n_ins   = 1'b1;
                n_k     = '0;
            end
            ST_CLR: begin
                l_we = (r_k < K_W'(LABEL_WORDS)) && (r_ins || (r_req.is_label && w_clr_txt));
                c_we = (r_k < K_W'(COMMENT_WORDS)) && (r_ins || (!r_req.is_label && w_clr_txt));
                n_k  = r_k + K_W'(1);
            end
            ST_WR: begin
                l_wa = {r_slot, w_widx[LW_AW-1:0]};
                c_wa = {r_slot, w_widx[CW_AW-1:0]};
                l_wd = w_wword;
                c_wd = w_wword;
                l_we = r_req.is_label;
                c_we = !r_req.is_label;
            end
            ST_RESP: begin
                o_res_valid = 1'b1;
            end
            ST_GRD: begin
            end
            ST_GOUT: begin
                o_res_valid = 1'b1;
                o_res.status = w_empty ? STAT_NOTFOUND : STAT_OK;
                o_res.text   = w_empty ? 64'd0 : w_gword;
                o_res.last   = w_glast;
                if (i_res_ready) n_k = r_k + K_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_kdata <= kmem[k_ra];
        if (k_we) kmem[k_wa] <= k_wd;
    end

    always_ff @(posedge i_clk) begin
        r_ldata <= lmem[l_ra];
        if (l_we) lmem[l_wa] <= l_wd;
    end

    always_ff @(posedge i_clk) begin
        r_cdata <= cmem[c_ra];
        if (c_we) cmem[c_wa] <= c_wd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_j      <= n_j;
        r_pos    <= n_pos;
        r_slot   <= n_slot;
        r_found  <= n_found;
        r_ins    <= n_ins;
        r_status <= n_status;
        r_k      <= n_k;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHWR) |-> (r_j > r_pos))
        else $error("shift wrote at or below the insert position");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INS) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the table");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INS) |-> (r_count < CNT_W'(CAPACITY)))
        else $error("insert into a full table");

endmodule

`default_nettype wire

FILE: src/sorted_address_annotation_table.sv
// ---------------------------------------------------------------------------
// sorted_address_annotation_table: sorted address to text annotation store
// Front intake queue, table engine and a registered result stage.
// ---------------------------------------------------------------------------
// The block keeps up to CAPACITY entries sorted by 64-bit address, each with
// a label and a comment text, and serves one request at a time from a short
// intake queue. Keys sit in a sorted key memory beside the slot that holds
// their texts, so an insert moves only keys, never text. Each step of the
// binary search reads one key from the key memory and then compares it. A
// set on a present address then writes the word, after a sweep that clears
// the text when word 0 is written. An insert first moves each entry above
// the insert position up by one, reading it and then writing it back, and
// then sweeps both texts clear. A get returns its text word by word, each
// word read from the registered text memory before it is offered. Results
// leave through an output register, so the engine never waits on a result
// that has been accepted downstream. No clearing pass follows reset: the
// entry count starts at zero and every entry is written on insert.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_address_annotation_table import saat_pkg::*; #(
    parameter int CAPACITY      = 256,
    parameter int LABEL_WORDS   = 8,
    parameter int COMMENT_WORDS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // tdata from bit 0: address[63:0], word_index[67:64], text_word[131:68],
    // zero padding [135:132]
    input  wire logic [135:0] i_s_axis_tdata,
    // tuser: req_type[1:0]
    input  wire logic [1:0]   i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // tdata: text_out[63:0]
    output logic [63:0]       o_m_axis_tdata,
    // tuser: status[1:0]
    output logic [1:0]        o_m_axis_tuser,
    // tlast: last_word
    output logic              o_m_axis_tlast
);

    logic q_valid, q_ready;
    t_req q_req;
    logic res_valid, res_ready;
    t_res res;
    logic r_valid;
    t_res r_res;

    saat_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_req_type   (i_s_axis_tuser),
        .i_address    (i_s_axis_tdata[63:0]),
        .i_word_index (i_s_axis_tdata[67:64]),
        .i_text_word  (i_s_axis_tdata[131:68]),
        .o_q_valid    (q_valid),
        .i_q_ready    (q_ready),
        .o_q_req      (q_req)
    );

    saat_back #(
        .CAPACITY      (CAPACITY),
        .LABEL_WORDS   (LABEL_WORDS),
        .COMMENT_WORDS (COMMENT_WORDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q_req     (q_req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // The output register takes a new beat whenever it is empty or its
    // current beat leaves in the same cycle.
    assign res_ready = !r_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (res_ready) begin
            r_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) r_res <= res;
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = r_res.text;
    assign o_m_axis_tuser  = r_res.status;
    assign o_m_axis_tlast  = r_res.last;

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the sorted address annotation table
// Drives set and get requests through the slave stream, predicts every result
// beat from its own copy of the table and checks the master stream against it.
// ---------------------------------------------------------------------------

// Holds the predicted table contents and the result beats still owed by the
// block. Entry order does not change any result, so an associative array
// keyed by address stands in for the sorted table.
class annotation_scoreboard;
    typedef logic [63:0] t_text [16];
    typedef struct {
        logic [1:0]  status;
        logic [63:0] text;
        logic        last;
    } t_beat;

    t_text labels [logic [63:0]];
    t_text comments [logic [63:0]];
    t_beat owed [$];
    int    mismatches = 0;

    function void push_beat(logic [1:0] st, logic [63:0] txt, logic lst);
        t_beat b;
        b.status = st;
        b.text   = txt;
        b.last   = lst;
        owed.push_back(b);
    endfunction

    task report(string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Works out the result beats caused by one accepted request.
    function void note_request(logic [1:0] req, logic [63:0] addr, logic [3:0] widx,
                               logic [63:0] word);
        t_text txt;
        logic  is_label;
        int    words;
        logic  zero_seen;
        is_label = (req == saat_pkg::REQ_SET_LABEL) || (req == saat_pkg::REQ_GET_LABEL);
        words    = is_label ? 8 : 16;
        if (req == saat_pkg::REQ_SET_LABEL || req == saat_pkg::REQ_SET_COMMENT) begin
            if (!comments.exists(addr)) begin
                if (comments.num() >= 256) begin
                    push_beat(saat_pkg::STAT_FULL, 64'd0, 1'b1);
                    return;
                end
                foreach (txt[i]) txt[i] = 64'd0;
                labels[addr]   = txt;
                comments[addr] = txt;
            end
            txt = is_label ? labels[addr] : comments[addr];
            if (widx < words) begin
                if (widx == 0) foreach (txt[i]) txt[i] = 64'd0;
                txt[widx] = word;
                if (widx == words - 1) txt[widx] &= saat_pkg::TOP_BYTE_CLEAR;
            end
            if (is_label) labels[addr] = txt;
            else comments[addr] = txt;
            push_beat(saat_pkg::STAT_OK, 64'd0, 1'b1);
        end else begin
            if (!comments.exists(addr)) begin
                push_beat(saat_pkg::STAT_NOTFOUND, 64'd0, 1'b1);
                return;
            end
            txt = is_label ? labels[addr] : comments[addr];
            if (txt[0][7:0] == 8'd0) begin
                push_beat(saat_pkg::STAT_NOTFOUND, 64'd0, 1'b1);
                return;
            end
            for (int k = 0; k < words; k++) begin
                zero_seen = 1'b0;
                for (int b = 0; b < 8; b++)
                    if (txt[k][8*b +: 8] == 8'd0) zero_seen = 1'b1;
                push_beat(saat_pkg::STAT_OK, txt[k], zero_seen || (k == words - 1));
                if (zero_seen) break;
            end
        end
    endfunction

    task check_beat(logic [1:0] st, logic [63:0] txt, logic lst);
        t_beat b;
        if (owed.size() == 0) begin
            report($sformatf("unexpected result beat status %0d text %h", st, txt));
            return;
        end
        b = owed.pop_front();
        if (st !== b.status) report($sformatf("status %0d, want %0d", st, b.status));
        if (txt !== b.text) report($sformatf("text %h, want %h", txt, b.text));
        if (lst !== b.last) report($sformatf("tlast %0d, want %0d", lst, b.last));
    endtask
endclass

module testbench;
    import saat_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int POOL_SIZE   = 24;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    // tdata from bit 0: address, word_index, text_word, zero padding.
    logic [135:0] i_s_axis_tdata = '0;
    // tuser: req_type.
    logic [1:0]   i_s_axis_tuser = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    // tdata: text_out.
    logic [63:0]  o_m_axis_tdata;
    // tuser: status.
    logic [1:0]   o_m_axis_tuser;
    logic         o_m_axis_tlast;

    annotation_scoreboard table_sb = new();
    logic [63:0] addr_pool [POOL_SIZE];
    logic        no_idle = 1'b0;
    int          quiet_cycles = 0;
    int          sent = 0;

    sorted_address_annotation_table uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Both streams are watched at the rising edge, where every signal still
    // holds the value it had before the edge. Accepted request beats feed
    // the predictor and accepted result beats are checked against it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                table_sb.note_request(i_s_axis_tuser, i_s_axis_tdata[63:0],
                                      i_s_axis_tdata[67:64], i_s_axis_tdata[131:68]);
            if (o_m_axis_tvalid && i_m_axis_tready)
                table_sb.check_beat(o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
        // Outside the no_idle stretch the receiver stalls in roughly one cycle out of six.
        i_m_axis_tready <= no_idle || ($urandom_range(99) >= 16);
    end

    // Watchdog: the run ends if neither stream moves for too long.
    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("testbench failed");
        $finish;
    end

    // Presents one request beat and holds it until the block takes it.
    task send_request(input logic [1:0] req, input logic [63:0] addr,
                      input logic [3:0] widx, input logic [63:0] word);
        while (!no_idle && $urandom_range(99) < 16) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= req;
        i_s_axis_tdata  <= {4'd0, word, widx, addr};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sent++;
    endtask

    task drain;
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (table_sb.owed.size() != 0) @(posedge i_clk);
    endtask

    // Eight text bytes, mostly non-zero so that gets run over several words.
    function automatic logic [63:0] text_bytes();
        logic [63:0] w;
        for (int b = 0; b < 8; b++) w[8*b +: 8] = 8'($urandom_range(255, 1));
        if ($urandom_range(3) == 0) w[8*$urandom_range(7) +: 8] = 8'd0;
        return w;
    endfunction

    initial begin
        logic [63:0] addr;
        logic [1:0]  kind;
        int          words;
        int          len;
        int          count;

        addr_pool[0] = 64'd0;
        addr_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = {$urandom, $urandom};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: absent gets, an empty entry, a full label at the lowest
        // key, a word past the label, a last word whose top byte is forced to zero,
        // and word 0 writes that end a text early or empty it.
        send_request(REQ_GET_LABEL, 64'd0, 4'd0, '1);
        send_request(REQ_GET_COMMENT, '1, 4'd0, '1);
        send_request(REQ_SET_LABEL, '1, 4'd9, '1);
        send_request(REQ_GET_LABEL, '1, 4'd0, 64'd0);
        send_request(REQ_GET_COMMENT, '1, 4'd0, 64'd0);
        for (int i = 0; i < 8; i++)
            send_request(REQ_SET_LABEL, 64'd0, i[3:0], '1);
        send_request(REQ_GET_LABEL, 64'd0, 4'd0, 64'd0);
        send_request(REQ_SET_COMMENT, '1, 4'd15, '1);
        send_request(REQ_GET_COMMENT, '1, 4'd0, 64'd0);
        send_request(REQ_SET_COMMENT, '1, 4'd0, 64'h1122_3344_5566_0077);
        send_request(REQ_GET_COMMENT, '1, 4'd0, 64'd0);
        send_request(REQ_SET_LABEL, 64'd0, 4'd0, 64'd0);
        send_request(REQ_GET_LABEL, 64'd0, 4'd0, 64'd0);

        // Hold off until the block has answered everything so far.
        drain();

        // Random part: mostly a text written from word 0 and then read back,
        // with loose single requests of any shape mixed in. A stretch in the
        // middle runs with neither side idling.
        count = 0;
        while (count < 130) begin
            no_idle = (count >= 50 && count < 90);
            addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
            if ($urandom_range(4) != 0) begin
                kind  = $urandom_range(1) ? REQ_SET_COMMENT : REQ_SET_LABEL;
                words = (kind == REQ_SET_LABEL) ? 8 : 16;
                len   = $urandom_range(words, 1);
                for (int i = 0; i < len; i++) begin
                    send_request(kind, addr, i[3:0], text_bytes());
                    count++;
                end
                send_request((kind == REQ_SET_LABEL) ? REQ_GET_LABEL : REQ_GET_COMMENT,
                             addr, 4'($urandom), {$urandom, $urandom});
                count++;
            end else begin
                send_request(2'($urandom_range(3)),
                             $urandom_range(1) ? addr : {$urandom, $urandom},
                             4'($urandom), {$urandom, $urandom});
                count++;
            end
        end
        no_idle = 1'b0;

        // Rewrite the label of six keys from the address pool and read both texts back.
        for (int i = 0; i < 6; i++) begin
            addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
            send_request(REQ_SET_LABEL, addr, 4'd0, text_bytes());
            send_request(REQ_GET_LABEL, addr, 4'd0, 64'd0);
            send_request(REQ_GET_COMMENT, addr, 4'd0, 64'd0);
        end

        drain();
        repeat (600) @(posedge i_clk);

        if (table_sb.mismatches == 0 && table_sb.owed.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule
